// ----- src/arbt_pkg.sv -----
// Shared types, constants and helper functions of the affine rectangle bounds transform.
package arbt_pkg;

    // Fixed-point format and derived widths
    localparam int FRAC_BITS = 16;
    localparam int D_W       = 32;
    localparam int PROD_W    = 2 * D_W - FRAC_BITS;
    localparam int SUM_W     = PROD_W + 2;

    // Register stages from the input to the result
    localparam int NSTG = 6;

    // Configuration port geometry
    localparam int IDX_W  = 3;
    localparam int ADDR_W = IDX_W + 2;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_COEF_A  = 3'd0;
    localparam logic [IDX_W-1:0] REG_COEF_B  = 3'd1;
    localparam logic [IDX_W-1:0] REG_COEF_C  = 3'd2;
    localparam logic [IDX_W-1:0] REG_COEF_D  = 3'd3;
    localparam logic [IDX_W-1:0] REG_SHIFT_X = 3'd4;
    localparam logic [IDX_W-1:0] REG_SHIFT_Y = 3'd5;

    // Operation codes
    localparam logic [1:0] FUNC_POINT = 2'd0;
    localparam logic [1:0] FUNC_SIZE  = 2'd1;
    localparam logic [1:0] FUNC_RECT  = 2'd2;
    localparam logic [1:0] FUNC_NONE  = 2'd3;

    // Value limits
    localparam logic signed [D_W-1:0] COEF_ONE = D_W'(1 << FRAC_BITS);
    localparam logic signed [D_W-1:0] MAX_D    = {1'b0, {(D_W-1){1'b1}}};
    localparam logic signed [D_W-1:0] MIN_D    = {1'b1, {(D_W-1){1'b0}}};

    typedef struct packed {
        logic signed [D_W-1:0] coef_a;
        logic signed [D_W-1:0] coef_b;
        logic signed [D_W-1:0] coef_c;
        logic signed [D_W-1:0] coef_d;
        logic signed [D_W-1:0] shift_x;
        logic signed [D_W-1:0] shift_y;
    } t_cfg;

    typedef struct packed {
        logic                  ovf;
        logic signed [D_W-1:0] val;
    } t_sat;

    // Corner operands: index 0 is the origin, index 1 the far edge
    typedef struct packed {
        logic [1:0]            func;
        logic                  ovf;
        logic [1:0][D_W-1:0]   xs;
        logic [1:0][D_W-1:0]   ys;
    } t_ops;

    // Truncated products
    typedef struct packed {
        logic [1:0]             func;
        logic                   ovf;
        logic [1:0][PROD_W-1:0] ax;
        logic [1:0][PROD_W-1:0] bx;
        logic [1:0][PROD_W-1:0] cy;
        logic [1:0][PROD_W-1:0] dy;
    } t_prod;

    // Transformed corners, index 2*i+j
    typedef struct packed {
        logic [1:0]          func;
        logic                ovf;
        logic [3:0][D_W-1:0] px;
        logic [3:0][D_W-1:0] py;
    } t_crn;

    // Pairwise extremes
    typedef struct packed {
        logic [1:0]          func;
        logic                ovf;
        logic [1:0][D_W-1:0] mnx;
        logic [1:0][D_W-1:0] mxx;
        logic [1:0][D_W-1:0] mny;
        logic [1:0][D_W-1:0] mxy;
    } t_pair;

    // Final extremes
    typedef struct packed {
        logic [1:0]            func;
        logic                  ovf;
        logic signed [D_W-1:0] minx;
        logic signed [D_W-1:0] maxx;
        logic signed [D_W-1:0] miny;
        logic signed [D_W-1:0] maxy;
    } t_box;

    // Result transaction
    typedef struct packed {
        logic [1:0]            func;
        logic signed [D_W-1:0] out_x;
        logic signed [D_W-1:0] out_y;
        logic signed [D_W-1:0] out_w;
        logic signed [D_W-1:0] out_h;
        logic                  sat;
    } t_res;

    // Clip a wide signed value to the data width
    function automatic t_sat sat_d(input logic signed [SUM_W-1:0] v);
        t_sat r;
        logic all_one;
        logic all_zero;
        all_one  = &v[SUM_W-1:D_W-1];
        all_zero = ~|v[SUM_W-1:D_W-1];
        if (all_one || all_zero) begin
            r.ovf = 1'b0;
            r.val = v[D_W-1:0];
        end else if (v[SUM_W-1]) begin
            r.ovf = 1'b1;
            r.val = MIN_D;
        end else begin
            r.ovf = 1'b1;
            r.val = MAX_D;
        end
        return r;
    endfunction

    function automatic logic [D_W-1:0] min_d(input logic [D_W-1:0] a, input logic [D_W-1:0] b);
        return ($signed(b) < $signed(a)) ? b : a;
    endfunction

    function automatic logic [D_W-1:0] max_d(input logic [D_W-1:0] a, input logic [D_W-1:0] b);
        return ($signed(b) > $signed(a)) ? b : a;
    endfunction

endpackage

// ----- src/arbt_cfg.sv -----
// Configuration register file with its APB-style access port.
module arbt_cfg import arbt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [D_W-1:0]    pwdata,
    output logic [D_W-1:0]    prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg             r_cfg;
    logic             wr_en;
    logic [IDX_W-1:0] idx;

    assign pready = 1'b1;
    assign idx    = paddr[ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;

    // Write the addressed register; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.coef_a  <= COEF_ONE;
            r_cfg.coef_b  <= '0;
            r_cfg.coef_c  <= '0;
            r_cfg.coef_d  <= COEF_ONE;
            r_cfg.shift_x <= '0;
            r_cfg.shift_y <= '0;
        end else if (wr_en) begin
            case (idx)
                REG_COEF_A:  r_cfg.coef_a  <= pwdata;
                REG_COEF_B:  r_cfg.coef_b  <= pwdata;
                REG_COEF_C:  r_cfg.coef_c  <= pwdata;
                REG_COEF_D:  r_cfg.coef_d  <= pwdata;
                REG_SHIFT_X: r_cfg.shift_x <= pwdata;
                REG_SHIFT_Y: r_cfg.shift_y <= pwdata;
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        case (idx)
            REG_COEF_A:  prdata = r_cfg.coef_a;
            REG_COEF_B:  prdata = r_cfg.coef_b;
            REG_COEF_C:  prdata = r_cfg.coef_c;
            REG_COEF_D:  prdata = r_cfg.coef_d;
            REG_SHIFT_X: prdata = r_cfg.shift_x;
            REG_SHIFT_Y: prdata = r_cfg.shift_y;
            default:     prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ----- src/arbt_prep.sv -----
// Operand stage: selects corner coordinates and clips the far rectangle edges.
module arbt_prep import arbt_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [1:0]            i_func,
    input  logic signed [D_W-1:0] i_in_x,
    input  logic signed [D_W-1:0] i_in_y,
    input  logic signed [D_W-1:0] i_in_w,
    input  logic signed [D_W-1:0] i_in_h,
    output t_ops                  o_ops
);

    t_ops                r_ops;
    t_ops                n_ops;
    logic signed [D_W:0] sum_x;
    logic signed [D_W:0] sum_y;
    t_sat                right;
    t_sat                bottom;

    // Far edges of the rectangle
    assign sum_x  = (D_W+1)'(i_in_x) + (D_W+1)'(i_in_w);
    assign sum_y  = (D_W+1)'(i_in_y) + (D_W+1)'(i_in_h);
    assign right  = sat_d(SUM_W'(sum_x));
    assign bottom = sat_d(SUM_W'(sum_y));

    // Points and sizes use one corner repeated so every corner agrees
    always_comb begin
        n_ops.func = i_func;
        case (i_func)
            FUNC_SIZE: begin
                n_ops.ovf   = 1'b0;
                n_ops.xs[0] = i_in_w;
                n_ops.xs[1] = i_in_w;
                n_ops.ys[0] = i_in_h;
                n_ops.ys[1] = i_in_h;
            end
            FUNC_RECT: begin
                n_ops.ovf   = right.ovf | bottom.ovf;
                n_ops.xs[0] = i_in_x;
                n_ops.xs[1] = right.val;
                n_ops.ys[0] = i_in_y;
                n_ops.ys[1] = bottom.val;
            end
            default: begin
                n_ops.ovf   = 1'b0;
                n_ops.xs[0] = i_in_x;
                n_ops.xs[1] = i_in_x;
                n_ops.ys[0] = i_in_y;
                n_ops.ys[1] = i_in_y;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ops <= n_ops;
        end
    end

    assign o_ops = r_ops;

endmodule

// ----- src/arbt_mul.sv -----
// Multiply stage: eight coefficient products, truncated by the fraction width.
module arbt_mul import arbt_pkg::*; (
    input  logic  i_clk,
    input  logic  i_en,
    input  t_cfg  i_cfg,
    input  t_ops  i_ops,
    output t_prod o_prod
);

    t_prod                   r_prod;
    t_prod                   n_prod;
    logic signed [2*D_W-1:0] m_ax [2];
    logic signed [2*D_W-1:0] m_bx [2];
    logic signed [2*D_W-1:0] m_cy [2];
    logic signed [2*D_W-1:0] m_dy [2];

    // Form full products and drop the fraction bits (floor)
    always_comb begin
        n_prod.func = i_ops.func;
        n_prod.ovf  = i_ops.ovf;
        for (int i = 0; i < 2; i++) begin
            m_ax[i] = $signed(i_cfg.coef_a) * $signed(i_ops.xs[i]);
            m_bx[i] = $signed(i_cfg.coef_b) * $signed(i_ops.xs[i]);
            m_cy[i] = $signed(i_cfg.coef_c) * $signed(i_ops.ys[i]);
            m_dy[i] = $signed(i_cfg.coef_d) * $signed(i_ops.ys[i]);
            n_prod.ax[i] = m_ax[i][2*D_W-1:FRAC_BITS];
            n_prod.bx[i] = m_bx[i][2*D_W-1:FRAC_BITS];
            n_prod.cy[i] = m_cy[i][2*D_W-1:FRAC_BITS];
            n_prod.dy[i] = m_dy[i][2*D_W-1:FRAC_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

// ----- src/arbt_corner.sv -----
// Corner stage: sums products and translation per corner and clips to 32 bits.
module arbt_corner import arbt_pkg::*; (
    input  logic  i_clk,
    input  logic  i_en,
    input  t_cfg  i_cfg,
    input  t_prod i_prod,
    output t_crn  o_crn
);

    t_crn                    r_crn;
    t_crn                    n_crn;
    logic signed [D_W-1:0]   tx;
    logic signed [D_W-1:0]   ty;
    logic signed [SUM_W-1:0] sx [4];
    logic signed [SUM_W-1:0] sy [4];
    t_sat                    cx [4];
    t_sat                    cy [4];

    // Sizes take the linear part only
    assign tx = (i_prod.func == FUNC_SIZE) ? '0 : i_cfg.shift_x;
    assign ty = (i_prod.func == FUNC_SIZE) ? '0 : i_cfg.shift_y;

    always_comb begin
        n_crn.func = i_prod.func;
        n_crn.ovf  = i_prod.ovf;
        for (int k = 0; k < 4; k++) begin
            sx[k] = SUM_W'($signed(i_prod.ax[k/2])) + SUM_W'($signed(i_prod.cy[k%2]))
                  + SUM_W'(tx);
            sy[k] = SUM_W'($signed(i_prod.bx[k/2])) + SUM_W'($signed(i_prod.dy[k%2]))
                  + SUM_W'(ty);
            cx[k] = sat_d(sx[k]);
            cy[k] = sat_d(sy[k]);
            n_crn.px[k] = cx[k].val;
            n_crn.py[k] = cy[k].val;
            n_crn.ovf   = n_crn.ovf | cx[k].ovf | cy[k].ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_crn <= n_crn;
        end
    end

    assign o_crn = r_crn;

endmodule

// ----- src/arbt_bbox.sv -----
// Bounding box stages: pairwise extremes, final extremes, then extent and result.
module arbt_bbox import arbt_pkg::*; (
    input  logic       i_clk,
    input  logic [2:0] i_en,
    input  t_crn       i_crn,
    output t_res       o_res
);

    t_pair r_pair;
    t_pair n_pair;
    t_box  r_box;
    t_box  n_box;
    t_res  r_res;
    t_res  n_res;
    t_sat  ext_w;
    t_sat  ext_h;

    // Extremes of corner pairs
    always_comb begin
        n_pair.func = i_crn.func;
        n_pair.ovf  = i_crn.ovf;
        for (int k = 0; k < 2; k++) begin
            n_pair.mnx[k] = min_d(i_crn.px[2*k], i_crn.px[2*k+1]);
            n_pair.mxx[k] = max_d(i_crn.px[2*k], i_crn.px[2*k+1]);
            n_pair.mny[k] = min_d(i_crn.py[2*k], i_crn.py[2*k+1]);
            n_pair.mxy[k] = max_d(i_crn.py[2*k], i_crn.py[2*k+1]);
        end
    end

    // Extremes over all four corners
    always_comb begin
        n_box.func = r_pair.func;
        n_box.ovf  = r_pair.ovf;
        n_box.minx = min_d(r_pair.mnx[0], r_pair.mnx[1]);
        n_box.maxx = max_d(r_pair.mxx[0], r_pair.mxx[1]);
        n_box.miny = min_d(r_pair.mny[0], r_pair.mny[1]);
        n_box.maxy = max_d(r_pair.mxy[0], r_pair.mxy[1]);
    end

    // Extent of the box and placement of the fields per operation
    assign ext_w = sat_d(SUM_W'(r_box.maxx) - SUM_W'(r_box.minx));
    assign ext_h = sat_d(SUM_W'(r_box.maxy) - SUM_W'(r_box.miny));

    always_comb begin
        n_res.func = r_box.func;
        case (r_box.func)
            FUNC_POINT: begin
                n_res.out_x = r_box.minx;
                n_res.out_y = r_box.miny;
                n_res.out_w = '0;
                n_res.out_h = '0;
                n_res.sat   = r_box.ovf;
            end
            FUNC_SIZE: begin
                n_res.out_x = '0;
                n_res.out_y = '0;
                n_res.out_w = r_box.minx;
                n_res.out_h = r_box.miny;
                n_res.sat   = r_box.ovf;
            end
            FUNC_RECT: begin
                n_res.out_x = r_box.minx;
                n_res.out_y = r_box.miny;
                n_res.out_w = ext_w.val;
                n_res.out_h = ext_h.val;
                n_res.sat   = r_box.ovf | ext_w.ovf | ext_h.ovf;
            end
            default: begin
                n_res.out_x = '0;
                n_res.out_y = '0;
                n_res.out_w = '0;
                n_res.out_h = '0;
                n_res.sat   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_pair <= n_pair;
        end
        if (i_en[1]) begin
            r_box <= n_box;
        end
        if (i_en[2]) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

// ----- src/affine_rect_bounds_transform.sv -----
// Top level of the affine rectangle bounds transform: pipeline control and stages.
//
//   Channel  Direction  Handshake            Payload
//   input    in         i_valid / o_stall    i_func, i_in_x, i_in_y, i_in_w, i_in_h
//   output   out        o_valid / i_stall    o_out_x, o_out_y, o_out_w, o_out_h, o_saturated
//   config   in         APB psel / penable   paddr, pwdata, prdata, pready
//
// Six register stages (operands, products, corners, pair extremes, box, result)
// lie in that order between the input and the output handshake. A new transaction
// can be accepted every cycle while no stall backs the pipeline up, before earlier
// ones are through. Each stage holds its contents while the stage after it is full
// and blocked, so bubbles close up under a stall.
// Synchronous reset empties the pipeline and restores the identity matrix.
module affine_rect_bounds_transform import arbt_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [D_W-1:0]        pwdata,
    output logic [D_W-1:0]        prdata,
    output logic                  pready,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [1:0]            i_func,
    input  logic signed [D_W-1:0] i_in_x,
    input  logic signed [D_W-1:0] i_in_y,
    input  logic signed [D_W-1:0] i_in_w,
    input  logic signed [D_W-1:0] i_in_h,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic signed [D_W-1:0] o_out_x,
    output logic signed [D_W-1:0] o_out_y,
    output logic signed [D_W-1:0] o_out_w,
    output logic signed [D_W-1:0] o_out_h,
    output logic                  o_saturated
);

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] en;
    t_cfg            cfg;
    t_ops            ops;
    t_prod           prod;
    t_crn            crn;
    t_res            res;

    // Load a stage when it is empty or the next stage moves on
    always_comb begin
        en[NSTG-1] = !r_vld[NSTG-1] || !i_stall;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    // Advance valid bits with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_stall = !en[0];
    assign o_valid = r_vld[NSTG-1];

    arbt_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    arbt_prep u_prep (
        .i_clk  (i_clk),
        .i_en   (en[0]),
        .i_func (i_func),
        .i_in_x (i_in_x),
        .i_in_y (i_in_y),
        .i_in_w (i_in_w),
        .i_in_h (i_in_h),
        .o_ops  (ops)
    );

    arbt_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (en[1]),
        .i_cfg  (cfg),
        .i_ops  (ops),
        .o_prod (prod)
    );

    arbt_corner u_corner (
        .i_clk  (i_clk),
        .i_en   (en[2]),
        .i_cfg  (cfg),
        .i_prod (prod),
        .o_crn  (crn)
    );

    arbt_bbox u_bbox (
        .i_clk (i_clk),
        .i_en  (en[5:3]),
        .i_crn (crn),
        .o_res (res)
    );

    assign o_out_x     = res.out_x;
    assign o_out_y     = res.out_y;
    assign o_out_w     = res.out_w;
    assign o_out_h     = res.out_h;
    assign o_saturated = res.sat;

    // Input is held back only when every stage is occupied
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (&r_vld))
        else $error("input stalled with an empty stage");

    // A size result carries nothing in the position fields
    a_size_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && res.func == FUNC_SIZE) |-> (o_out_x == '0 && o_out_y == '0))
        else $error("size result with non-zero position");

    // A bounding box never has a negative extent
    a_box_ext: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && res.func == FUNC_RECT) |-> (!o_out_w[D_W-1] && !o_out_h[D_W-1]))
        else $error("negative bounding box extent");

    // Reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

// ----- tb/affine_rect_bounds_transform_test.sv -----
// Self-checking testbench for the affine rectangle bounds transform.
module affine_rect_bounds_transform_test;
    import arbt_pkg::*;

    localparam int PHASE_ITEMS = 130;
    localparam int PHASES      = 8;
    localparam int DRAIN_GAP   = 8;
    localparam int IDLE_LIMIT  = 2000;
    localparam int HOLD_CYCLES = 48;
    localparam int PRINT_CAP   = 40;

    // Register slots beyond the matrix; writes there must be ignored
    localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam logic [D_W-1:0] NEG_ONE = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]     func;
        logic [D_W-1:0] x;
        logic [D_W-1:0] y;
        logic [D_W-1:0] w;
        logic [D_W-1:0] h;
    } shape_t;

    typedef struct packed {
        logic [D_W-1:0] x;
        logic [D_W-1:0] y;
        logic [D_W-1:0] w;
        logic [D_W-1:0] h;
        logic           sat;
    } box_t;

    typedef struct packed {
        shape_t item;
        logic   typed;
        box_t   want;
    } probe_t;

    typedef enum int {
        MIX_SCALE, ALL_MAX, FULL_RANDOM, ALL_MIN,
        SMALL_RANDOM, ZERO_LINEAR, SMALL_UNSHIFTED, PURE_SHIFT
    } matrix_kind_e;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_W-1:0]     paddr;
    logic [D_W-1:0]        pwdata;
    logic [D_W-1:0]        prdata;
    logic                  pready;
    logic                  i_valid;
    logic                  o_stall;
    logic [1:0]            i_func;
    logic signed [D_W-1:0] i_in_x;
    logic signed [D_W-1:0] i_in_y;
    logic signed [D_W-1:0] i_in_w;
    logic signed [D_W-1:0] i_in_h;
    logic                  o_valid;
    logic                  i_stall;
    logic signed [D_W-1:0] o_out_x;
    logic signed [D_W-1:0] o_out_y;
    logic signed [D_W-1:0] o_out_w;
    logic signed [D_W-1:0] o_out_h;
    logic                  o_saturated;

    // Matrix as the block should hold it, and boxes still owed by the block
    t_cfg matrix;
    box_t pending_boxes [$];
    box_t oldest;

    int send_idle_pct;
    int stall_pct;
    int hold_left;
    int n_errors;
    int n_results;
    int n_saturated;
    int n_held;
    int n_settings;
    int func_seen [4];

    // Directed transactions; the typed boxes hold under the reset (identity) matrix
    probe_t probe_tab [18] = '{
        '{'{FUNC_POINT, MAX_D, MIN_D, 32'h1234_5678, 32'h8765_4321}, 1'b1,
          '{MAX_D, MIN_D, 32'd0, 32'd0, 1'b0}},
        '{'{FUNC_POINT, 32'h0001_8000, 32'hFFFE_8000, 32'd0, 32'd0}, 1'b1,
          '{32'h0001_8000, 32'hFFFE_8000, 32'd0, 32'd0, 1'b0}},
        '{'{FUNC_SIZE, MAX_D, MIN_D, MIN_D, MAX_D}, 1'b1,
          '{32'd0, 32'd0, MIN_D, MAX_D, 1'b0}},
        '{'{FUNC_SIZE, 32'd0, 32'd0, 32'h0003_0000, NEG_ONE}, 1'b1,
          '{32'd0, 32'd0, 32'h0003_0000, NEG_ONE, 1'b0}},
        '{'{FUNC_NONE, NEG_ONE, NEG_ONE, NEG_ONE, NEG_ONE}, 1'b1, '0},
        '{'{FUNC_NONE, MAX_D, MIN_D, MAX_D, MIN_D}, 1'b1, '0},
        '{'{FUNC_RECT, MAX_D, 32'd0, 32'd1, 32'd0}, 1'b1,
          '{MAX_D, 32'd0, 32'd0, 32'd0, 1'b1}},
        '{'{FUNC_RECT, MIN_D, MIN_D, MIN_D, MIN_D}, 1'b1,
          '{MIN_D, MIN_D, 32'd0, 32'd0, 1'b1}},
        '{'{FUNC_RECT, MIN_D, MAX_D, MAX_D, MIN_D}, 1'b1,
          '{MIN_D, NEG_ONE, MAX_D, MAX_D, 1'b1}},
        '{'{FUNC_RECT, 32'h0064_0000, 32'd0, 32'hFFCE_0000, 32'hFFFF_0000}, 1'b1,
          '{32'h0032_0000, 32'hFFFF_0000, 32'h0032_0000, 32'h0001_0000, 1'b0}},
        '{'{FUNC_RECT, 32'd0, 32'd0, 32'd0, 32'd0}, 1'b1, '0},
        '{'{FUNC_RECT, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000},
          1'b1, '{32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 1'b0}},
        '{'{FUNC_POINT, 32'h7FFF_0001, 32'h8000_FFFF, 32'd0, 32'd0}, 1'b0, '0},
        '{'{FUNC_SIZE, 32'd0, 32'd0, 32'h0000_0001, 32'hFFFF_FFFE}, 1'b0, '0},
        '{'{FUNC_RECT, 32'h4000_0000, 32'hC000_0000, 32'h4000_0000, 32'hC000_0000},
          1'b0, '0},
        '{'{FUNC_RECT, 32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA},
          1'b0, '0},
        '{'{FUNC_POINT, 32'hAAAA_AAAA, 32'h5555_5555, 32'd0, 32'd0}, 1'b0, '0},
        '{'{FUNC_SIZE, 32'd0, 32'd0, 32'h5555_5555, 32'hAAAA_AAAA}, 1'b0, '0}
    };

    affine_rect_bounds_transform DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_func      (i_func),
        .i_in_x      (i_in_x),
        .i_in_y      (i_in_y),
        .i_in_w      (i_in_w),
        .i_in_h      (i_in_h),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_x     (o_out_x),
        .o_out_y     (o_out_y),
        .o_out_w     (o_out_w),
        .o_out_h     (o_out_h),
        .o_saturated (o_saturated)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        n_errors++;
        if (n_errors <= PRINT_CAP) $display("mismatch at %0t: %s", $time, msg);
    endtask

    // Clip to the signed 32-bit range, noting any saturation
    function automatic longint clip32(input longint v, inout bit clipped);
        if (v > longint'($signed(MAX_D))) begin
            clipped = 1'b1;
            return longint'($signed(MAX_D));
        end
        if (v < longint'($signed(MIN_D))) begin
            clipped = 1'b1;
            return longint'($signed(MIN_D));
        end
        return v;
    endfunction

    // Map one point through the matrix; truncated products, lossless sum, then clip
    function automatic void map_corner(input longint x, input longint y, input bit translate,
                                       output longint ox, output longint oy,
                                       inout bit clipped);
        longint ca, cb, cc, cd, rx, ry;
        ca = longint'($signed(matrix.coef_a));
        cb = longint'($signed(matrix.coef_b));
        cc = longint'($signed(matrix.coef_c));
        cd = longint'($signed(matrix.coef_d));
        rx = ((ca * x) >>> FRAC_BITS) + ((cc * y) >>> FRAC_BITS);
        ry = ((cb * x) >>> FRAC_BITS) + ((cd * y) >>> FRAC_BITS);
        if (translate) begin
            rx += longint'($signed(matrix.shift_x));
            ry += longint'($signed(matrix.shift_y));
        end
        ox = clip32(rx, clipped);
        oy = clip32(ry, clipped);
    endfunction

    // Expected result of one transaction under the current matrix
    function automatic box_t bound_shape(input shape_t s);
        box_t   r;
        longint xs [2];
        longint ys [2];
        longint px, py, minx, maxx, miny, maxy, rx, ry, rw, rh;
        bit     clipped;
        int     i, j;
        clipped = 1'b0;
        rx = 0; ry = 0; rw = 0; rh = 0;
        minx = 0; maxx = 0; miny = 0; maxy = 0;
        case (s.func)
            FUNC_POINT: begin
                map_corner(longint'($signed(s.x)), longint'($signed(s.y)), 1'b1,
                           rx, ry, clipped);
            end
            FUNC_SIZE: begin
                map_corner(longint'($signed(s.w)), longint'($signed(s.h)), 1'b0,
                           rw, rh, clipped);
            end
            FUNC_RECT: begin
                // Far edges clip before the corners are mapped
                xs[0] = longint'($signed(s.x));
                ys[0] = longint'($signed(s.y));
                xs[1] = clip32(xs[0] + longint'($signed(s.w)), clipped);
                ys[1] = clip32(ys[0] + longint'($signed(s.h)), clipped);
                for (i = 0; i < 2; i++) begin
                    for (j = 0; j < 2; j++) begin
                        map_corner(xs[i], ys[j], 1'b1, px, py, clipped);
                        if (i == 0 && j == 0) begin
                            minx = px; maxx = px; miny = py; maxy = py;
                        end else begin
                            if (px < minx) minx = px;
                            if (px > maxx) maxx = px;
                            if (py < miny) miny = py;
                            if (py > maxy) maxy = py;
                        end
                    end
                end
                rx = minx;
                ry = miny;
                rw = clip32(maxx - minx, clipped);
                rh = clip32(maxy - miny, clipped);
            end
            default: ;
        endcase
        r.x   = rx[D_W-1:0];
        r.y   = ry[D_W-1:0];
        r.w   = rw[D_W-1:0];
        r.h   = rh[D_W-1:0];
        r.sat = clipped;
        return r;
    endfunction

    // Mostly small signed values, with full-range noise and the extremes
    function automatic logic [D_W-1:0] pick_value();
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(3))
                    0:       return MAX_D;
                    1:       return MIN_D;
                    2:       return '0;
                    default: return NEG_ONE;
                endcase
            end
            1, 2:    return $urandom;
            default: return $urandom_range(32'h0020_0000) - 32'h0010_0000;
        endcase
    endfunction

    function automatic shape_t random_shape();
        shape_t s;
        case ($urandom_range(9))
            0:       s.func = FUNC_NONE;
            1, 2:    s.func = FUNC_POINT;
            3, 4:    s.func = FUNC_SIZE;
            default: s.func = FUNC_RECT;
        endcase
        s.x = pick_value();
        s.y = pick_value();
        s.w = pick_value();
        s.h = pick_value();
        return s;
    endfunction

    // Write one register over APB, then read back a matrix register; called at a falling edge
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [D_W-1:0] value);
        logic [D_W-1:0] rdata;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_COEF_A:  matrix.coef_a  = value;
            REG_COEF_B:  matrix.coef_b  = value;
            REG_COEF_C:  matrix.coef_c  = value;
            REG_COEF_D:  matrix.coef_d  = value;
            REG_SHIFT_X: matrix.shift_x = value;
            REG_SHIFT_Y: matrix.shift_y = value;
            default: ;
        endcase
        @(negedge i_clk);
        if (idx <= REG_SHIFT_Y) begin
            // Read back through a fresh setup and access pair
            penable <= 1'b0;
            pwrite  <= 1'b0;
            @(negedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (!pready);
            rdata = prdata;
            if (rdata !== value)
                report_mismatch($sformatf("register %0d read %h, written %h",
                                          idx, rdata, value));
            @(negedge i_clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    // Load a whole matrix; the block must be idle
    task automatic load_matrix(input matrix_kind_e kind);
        logic [D_W-1:0] ca, cb, cc, cd, sx, sy;
        case (kind)
            MIX_SCALE: begin
                ca = 32'h0002_0000; cb = 32'h0000_8000; cc = 32'hFFFF_8000;
                cd = 32'hFFFE_8000; sx = 32'h0064_4000; sy = 32'hFFF9_0000;
            end
            ALL_MAX: begin
                ca = MAX_D; cb = MAX_D; cc = MAX_D; cd = MAX_D; sx = MAX_D; sy = MAX_D;
            end
            ALL_MIN: begin
                ca = MIN_D; cb = MIN_D; cc = MIN_D; cd = MIN_D; sx = MIN_D; sy = MIN_D;
            end
            FULL_RANDOM: begin
                ca = $urandom; cb = $urandom; cc = $urandom;
                cd = $urandom; sx = $urandom; sy = $urandom;
            end
            SMALL_RANDOM, SMALL_UNSHIFTED: begin
                ca = $urandom_range(32'h0008_0000) - 32'h0004_0000;
                cb = $urandom_range(32'h0008_0000) - 32'h0004_0000;
                cc = $urandom_range(32'h0008_0000) - 32'h0004_0000;
                cd = $urandom_range(32'h0008_0000) - 32'h0004_0000;
                sx = $urandom_range(32'h07D0_0000) - 32'h03E8_0000;
                sy = $urandom_range(32'h07D0_0000) - 32'h03E8_0000;
                if (kind == SMALL_UNSHIFTED) begin
                    sx = '0;
                    sy = '0;
                end
            end
            ZERO_LINEAR: begin
                ca = '0; cb = '0; cc = '0; cd = '0; sx = $urandom; sy = $urandom;
            end
            default: begin
                ca = COEF_ONE; cb = '0; cc = '0; cd = COEF_ONE;
                sx = $urandom_range(32'h07D0_0000) - 32'h03E8_0000;
                sy = $urandom_range(32'h07D0_0000) - 32'h03E8_0000;
            end
        endcase
        write_reg(REG_COEF_A, ca);
        write_reg(REG_COEF_B, cb);
        write_reg(REG_COEF_C, cc);
        write_reg(REG_COEF_D, cd);
        write_reg(REG_SHIFT_X, sx);
        write_reg(REG_SHIFT_Y, sy);
        write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, $urandom);
        n_settings++;
    endtask

    // Offer one transaction after a random gap; called and returns at a falling edge
    task automatic send_shape(input shape_t s, input bit typed, input box_t want);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_func  <= s.func;
        i_in_x  <= s.x;
        i_in_y  <= s.y;
        i_in_w  <= s.w;
        i_in_h  <= s.h;
        do @(posedge i_clk); while (o_stall);
        pending_boxes.push_back(typed ? want : bound_shape(s));
        func_seen[s.func]++;
        @(negedge i_clk);
    endtask

    // Stop offering and wait until every owed result has arrived
    task automatic drain_pipe();
        i_valid <= 1'b0;
        while (pending_boxes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_GAP) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic run_table(input bit use_typed);
        int k;
        for (k = 0; k < $size(probe_tab); k++)
            send_shape(probe_tab[k].item, use_typed && probe_tab[k].typed, probe_tab[k].want);
    endtask

    // Result side: random stalls, plus a long hold when requested
    initial begin : receiver
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else begin
                i_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // Compare each accepted result with the oldest owed box
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            n_results++;
            if (o_saturated) n_saturated++;
            if (pending_boxes.size() == 0) begin
                report_mismatch("result with no transaction pending");
            end else begin
                oldest = pending_boxes.pop_front();
                if (o_out_x !== oldest.x)
                    report_mismatch($sformatf("out_x got %h want %h", o_out_x, oldest.x));
                if (o_out_y !== oldest.y)
                    report_mismatch($sformatf("out_y got %h want %h", o_out_y, oldest.y));
                if (o_out_w !== oldest.w)
                    report_mismatch($sformatf("out_w got %h want %h", o_out_w, oldest.w));
                if (o_out_h !== oldest.h)
                    report_mismatch($sformatf("out_h got %h want %h", o_out_h, oldest.h));
                if (o_saturated !== oldest.sat)
                    report_mismatch($sformatf("saturated got %b want %b",
                                              o_saturated, oldest.sat));
            end
        end
    end

    // Abort when nothing moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge i_clk);
            if (i_valid && o_stall) n_held++;
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || (psel && penable))
                quiet = 0;
            else
                quiet++;
        end
        $display("affine_rect_bounds_transform_test: errors");
        $finish;
    end

    initial begin : stimulus
        int p, k;
        i_rst_n = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        i_valid = 1'b0;
        i_func  = FUNC_POINT;
        i_in_x  = '0;
        i_in_y  = '0;
        i_in_w  = '0;
        i_in_h  = '0;
        matrix  = '{COEF_ONE, '0, '0, COEF_ONE, '0, '0};

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed pass under reset values, then again under a skewed matrix
        run_table(1'b1);
        drain_pipe();
        load_matrix(MIX_SCALE);
        run_table(1'b0);

        // Random phases, each with its own matrix and idling mix
        for (p = 0; p < PHASES; p++) begin
            drain_pipe();
            load_matrix(matrix_kind_e'(p));
            case (p % 4)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 56; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 56; end
                default: begin send_idle_pct = 13; stall_pct = 13; end
            endcase
            for (k = 0; k < PHASE_ITEMS; k++) begin
                // Back the pipeline up against a held receiver
                if (k == 40 && p % 4 == 0) hold_left = HOLD_CYCLES;
                // Let the pipeline empty out before carrying on
                if (k == 90) drain_pipe();
                send_shape(random_shape(), 1'b0, '0);
            end
        end
        drain_pipe();

        $display("%0d transactions: %0d point, %0d size, %0d rect, %0d unused; %0d matrices",
                 func_seen[FUNC_POINT] + func_seen[FUNC_SIZE] + func_seen[FUNC_RECT]
                 + func_seen[FUNC_NONE],
                 func_seen[FUNC_POINT], func_seen[FUNC_SIZE], func_seen[FUNC_RECT],
                 func_seen[FUNC_NONE], n_settings);
        $display("%0d results checked, %0d saturated, input held %0d cycles, %0d mismatches",
                 n_results, n_saturated, n_held, n_errors);
        if (n_errors == 0)
            $display("affine_rect_bounds_transform_test: clean");
        else
            $display("affine_rect_bounds_transform_test: errors");
        $finish;
    end

endmodule
